/* hdl/cdq_pkg.sv */
// ----------------------------------------------------------------------------
// cdq_pkg: shared types for the circular deque
// Item and result payloads, operation and status codes, cell control word.
// ----------------------------------------------------------------------------
package cdq_pkg;

    localparam int unsigned DataW = 32;
    localparam int unsigned CfgW  = 5;

    typedef enum logic [1:0] {
        OP_PUSH_FRONT = 2'd0,
        OP_PUSH_BACK  = 2'd1,
        OP_POP_FRONT  = 2'd2,
        OP_POP_BACK   = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_DONE       = 2'd0,
        ST_PUSH_FULL  = 2'd1,
        ST_POP_EMPTY  = 2'd2
    } t_status;

    typedef struct packed {
        t_op                      op;
        logic signed [DataW-1:0]  push_value;
    } t_in_item;

    typedef struct packed {
        logic signed [DataW-1:0]  front_value;
        logic signed [DataW-1:0]  back_value;
        logic                     is_empty;
        logic                     is_full;
        t_status                  status;
    } t_out_item;

    // Each cell holds one slot of the front-ordered chain (f) and one slot of
    // the back-ordered chain (r). Shift right moves toward the far end.
    typedef struct packed {
        logic f_shr;
        logic f_shl;
        logic f_wr;
        logic r_shr;
        logic r_shl;
        logic r_wr;
    } t_cell_ctl;

endpackage

/* hdl/cdq_cell.sv */
// ----------------------------------------------------------------------------
// cdq_cell: one slot of the deque chain
// Holds entry i counted from the front and entry i counted from the back;
// shifts with its neighbors or takes the pushed value when selected.
// ----------------------------------------------------------------------------
module cdq_cell (
    input  logic                                i_clk,
    input  cdq_pkg::t_cell_ctl                  i_ctl,
    input  logic                                i_sel,
    input  logic signed [cdq_pkg::DataW-1:0]    i_value,
    input  logic signed [cdq_pkg::DataW-1:0]    i_left_f,
    input  logic signed [cdq_pkg::DataW-1:0]    i_right_f,
    input  logic signed [cdq_pkg::DataW-1:0]    i_left_r,
    input  logic signed [cdq_pkg::DataW-1:0]    i_right_r,
    output logic signed [cdq_pkg::DataW-1:0]    o_f,
    output logic signed [cdq_pkg::DataW-1:0]    o_r
);

    logic signed [cdq_pkg::DataW-1:0] r_f, n_f;
    logic signed [cdq_pkg::DataW-1:0] r_r, n_r;

    always_comb begin
        n_f = r_f;
        if (i_ctl.f_shr) begin
            n_f = i_left_f;
        end else if (i_ctl.f_shl) begin
            n_f = i_right_f;
        end else if (i_ctl.f_wr && i_sel) begin
            n_f = i_value;
        end

        n_r = r_r;
        if (i_ctl.r_shr) begin
            n_r = i_left_r;
        end else if (i_ctl.r_shl) begin
            n_r = i_right_r;
        end else if (i_ctl.r_wr && i_sel) begin
            n_r = i_value;
        end
    end

    always_ff @(posedge i_clk) begin
        r_f <= n_f;
        r_r <= n_r;
    end

    assign o_f = r_f;
    assign o_r = r_r;

endmodule

/* hdl/circular_deque.sv */
// ----------------------------------------------------------------------------
// circular_deque: double-ended queue built as a chain of cells
// Push and pop at either end, with full and empty rejection.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_ready / i_in_item) carries one operation
//   per item. Output channel (o_out_valid / i_out_ready / o_out_item) returns
//   exactly one result per item: front and back values (zero when empty),
//   empty and full flags, and a status code.
//   The result is registered: it is valid the cycle after the item is accepted.
//   Throughput: one item per cycle while the receiver keeps up. Every cell updates
//   in the same cycle; the count, chain and status registers are all an item walks.
//   When the receiver stalls the result is held and o_in_ready drops; a new
//   item is taken in the same cycle the held result is taken.
//   The chain keeps two copies of the contents: one ordered from the front
//   and one from the back, so both ends sit at cell 0.
//   Configuration: i_cfg_we writes capacity_in_use (0 acts as 1, values above
//   DEPTH saturate) and empties the deque; write only while idle.
//   Reset: deque empty, capacity min(16, DEPTH), no result pending. Stored
//   entries are not cleared.
// ----------------------------------------------------------------------------
module circular_deque #(
    parameter int unsigned DEPTH = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [cdq_pkg::CfgW-1:0]        i_cfg_wdata,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  cdq_pkg::t_in_item               i_in_item,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output cdq_pkg::t_out_item              o_out_item
);

    localparam int unsigned CntW    = $clog2(DEPTH + 1);
    localparam int unsigned CmpW    = (CntW > cdq_pkg::CfgW) ? CntW : cdq_pkg::CfgW;
    localparam int unsigned CapRst  = (DEPTH < 16) ? DEPTH : 16;

    logic [CntW-1:0]        r_count, n_count;
    logic [CntW-1:0]        r_cap, n_cap;
    logic                   r_out_valid;
    cdq_pkg::t_status       r_status, n_status;
    cdq_pkg::t_cell_ctl     w_ctl;
    logic                   w_accept;
    logic                   w_full;
    logic                   w_empty;
    logic [CmpW-1:0]        w_cfg_ext;

    logic signed [cdq_pkg::DataW-1:0] w_f [DEPTH];
    logic signed [cdq_pkg::DataW-1:0] w_r [DEPTH];

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_full     = (r_count >= r_cap);
    assign w_empty    = (r_count == '0);
    assign w_cfg_ext  = CmpW'(i_cfg_wdata);

    // Effective capacity of a configuration write
    always_comb begin
        if (w_cfg_ext == '0) begin
            n_cap = CntW'(1);
        end else if (w_cfg_ext > CmpW'(DEPTH)) begin
            n_cap = CntW'(DEPTH);
        end else begin
            n_cap = CntW'(w_cfg_ext);
        end
    end

    always_comb begin
        w_ctl    = '0;
        n_count  = r_count;
        n_status = cdq_pkg::ST_DONE;
        unique case (i_in_item.op)
            cdq_pkg::OP_PUSH_FRONT: begin
                if (w_full) begin
                    n_status = cdq_pkg::ST_PUSH_FULL;
                end else begin
                    w_ctl.f_shr = w_accept;
                    w_ctl.r_wr  = w_accept;
                    n_count     = r_count + CntW'(1);
                end
            end
            cdq_pkg::OP_PUSH_BACK: begin
                if (w_full) begin
                    n_status = cdq_pkg::ST_PUSH_FULL;
                end else begin
                    w_ctl.r_shr = w_accept;
                    w_ctl.f_wr  = w_accept;
                    n_count     = r_count + CntW'(1);
                end
            end
            cdq_pkg::OP_POP_FRONT: begin
                if (w_empty) begin
                    n_status = cdq_pkg::ST_POP_EMPTY;
                end else begin
                    w_ctl.f_shl = w_accept;
                    n_count     = r_count - CntW'(1);
                end
            end
            cdq_pkg::OP_POP_BACK: begin
                if (w_empty) begin
                    n_status = cdq_pkg::ST_POP_EMPTY;
                end else begin
                    w_ctl.r_shl = w_accept;
                    n_count     = r_count - CntW'(1);
                end
            end
            default: begin
                n_status = cdq_pkg::ST_DONE;
            end
        endcase
    end

    generate
        for (genvar gi = 0; gi < DEPTH; gi++) begin : g_cell
            logic signed [cdq_pkg::DataW-1:0] w_left_f, w_left_r;
            logic signed [cdq_pkg::DataW-1:0] w_right_f, w_right_r;

            if (gi == 0) begin : g_head
                assign w_left_f = i_in_item.push_value;
                assign w_left_r = i_in_item.push_value;
            end else begin : g_mid
                assign w_left_f = w_f[gi-1];
                assign w_left_r = w_r[gi-1];
            end

            // Past the tail nothing is ever read, so the last cell refills from input
            if (gi == DEPTH - 1) begin : g_tail
                assign w_right_f = i_in_item.push_value;
                assign w_right_r = i_in_item.push_value;
            end else begin : g_body
                assign w_right_f = w_f[gi+1];
                assign w_right_r = w_r[gi+1];
            end

            cdq_cell u_cell (
                .i_clk      (i_clk),
                .i_ctl      (w_ctl),
                .i_sel      (r_count == CntW'(gi)),
                .i_value    (i_in_item.push_value),
                .i_left_f   (w_left_f),
                .i_right_f  (w_right_f),
                .i_left_r   (w_left_r),
                .i_right_r  (w_right_r),
                .o_f        (w_f[gi]),
                .o_r        (w_r[gi])
            );
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_cap       <= CntW'(CapRst);
            r_out_valid <= 1'b0;
            r_status    <= cdq_pkg::ST_DONE;
        end else begin
            if (i_cfg_we) begin
                r_cap   <= n_cap;
                r_count <= '0;
            end else if (w_accept) begin
                r_count <= n_count;
            end
            if (w_accept) begin
                r_status    <= n_status;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid             = r_out_valid;
    assign o_out_item.front_value  = w_empty ? '0 : w_f[0];
    assign o_out_item.back_value   = w_empty ? '0 : w_r[0];
    assign o_out_item.is_empty     = w_empty;
    assign o_out_item.is_full      = (r_count == r_cap);
    assign o_out_item.status       = r_status;

    a_count_le_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= r_cap)
        else $error("entry count exceeds capacity");

    a_reject_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && !i_cfg_we && n_status != cdq_pkg::ST_DONE)
        |=> (r_count == $past(r_count) && r_status != cdq_pkg::ST_DONE))
        else $error("rejected item changed the count");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && !i_cfg_we && n_status == cdq_pkg::ST_DONE)
        |=> (r_count != $past(r_count)))
        else $error("accepted operation left the count unchanged");

    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.is_empty)
        |-> (o_out_item.front_value == '0 && o_out_item.back_value == '0))
        else $error("empty result carries nonzero values");

endmodule

/* tb/circular_deque_tb.sv */
// ----------------------------------------------------------------------------
// circular_deque_tb: self-checking testbench for the circular deque
// Drives push/pop items at both ends over several capacities, mirrors the
// deque in a shadow copy and checks every result field against it. Runs with
// and without random idling on both channels, plus a long receiver stall.
// ----------------------------------------------------------------------------
module circular_deque_tb;

    localparam int unsigned Depth         = 16;
    localparam int          ResultLatency = 1;
    localparam int          DrainLimit    = 5000;
    localparam int          MaxReports    = 10;
    localparam int          ItemsPerPhase = 55;

    typedef enum int {
        IDLE_NONE,
        IDLE_TX,
        IDLE_RX,
        IDLE_BOTH
    } t_idle_mode;

    logic                     clk;
    logic                     rst_n     = 1'b0;
    logic                     cfg_we    = 1'b0;
    logic [cdq_pkg::CfgW-1:0] cfg_wdata = '0;
    logic                     in_valid  = 1'b0;
    logic                     in_ready;
    cdq_pkg::t_in_item        in_item   = '0;
    logic                     out_valid;
    logic                     out_ready = 1'b0;
    cdq_pkg::t_out_item       out_item;

    // shadow copy of the deque
    logic [cdq_pkg::DataW-1:0] shadow_slots [Depth];
    logic [3:0]                shadow_front;
    logic [3:0]                shadow_back;
    logic [4:0]                shadow_count;
    logic [4:0]                shadow_cap_reg;

    cdq_pkg::t_out_item predicted_views [$];
    int        mismatches   = 0;
    int        tx_idle_pct  = 0;
    int        rx_stall_pct = 0;
    int        rx_hold_left = 0;
    bit        valid_up     = 1'b0;

    circular_deque #(
        .DEPTH(Depth)
    ) dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_wdata(cfg_wdata),
        .i_in_valid (in_valid),
        .o_in_ready (in_ready),
        .i_in_item  (in_item),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_out_item (out_item)
    );

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial begin
        #(8 * 400000);
        $display("circular_deque_tb: done, errors");
        $finish;
    end

    function automatic logic [4:0] effective_cap();
        if (shadow_cap_reg == 5'd0) return 5'd1;
        if (shadow_cap_reg > Depth) return 5'(Depth);
        return shadow_cap_reg;
    endfunction

    function automatic cdq_pkg::t_out_item deque_apply(cdq_pkg::t_in_item item);
        logic [4:0]         cap;
        cdq_pkg::t_status   st;
        cdq_pkg::t_out_item view;
        cap = effective_cap();
        st  = cdq_pkg::ST_DONE;
        if (item.op == cdq_pkg::OP_PUSH_FRONT || item.op == cdq_pkg::OP_PUSH_BACK) begin
            if (shadow_count >= cap) begin
                st = cdq_pkg::ST_PUSH_FULL;
            end else begin
                if (shadow_count == 5'd0) begin
                    // first entry always lands in slot 0
                    shadow_front    = 4'd0;
                    shadow_back     = 4'd0;
                    shadow_slots[0] = item.push_value;
                end else if (item.op == cdq_pkg::OP_PUSH_FRONT) begin
                    shadow_front = (shadow_front == 4'd0) ? 4'(cap - 5'd1)
                                                          : shadow_front - 4'd1;
                    shadow_slots[shadow_front] = item.push_value;
                end else begin
                    shadow_back = (shadow_back >= cap - 5'd1) ? 4'd0 : shadow_back + 4'd1;
                    shadow_slots[shadow_back] = item.push_value;
                end
                shadow_count++;
            end
        end else if (shadow_count == 5'd0) begin
            st = cdq_pkg::ST_POP_EMPTY;
        end else if (shadow_count == 5'd1) begin
            shadow_count = 5'd0;
            shadow_front = 4'd0;
            shadow_back  = 4'd0;
        end else begin
            if (item.op == cdq_pkg::OP_POP_FRONT) begin
                shadow_front = (shadow_front >= cap - 5'd1) ? 4'd0 : shadow_front + 4'd1;
            end else begin
                shadow_back = (shadow_back == 4'd0) ? 4'(cap - 5'd1) : shadow_back - 4'd1;
            end
            shadow_count--;
        end
        view.front_value = (shadow_count == 5'd0) ? '0 : shadow_slots[shadow_front];
        view.back_value  = (shadow_count == 5'd0) ? '0 : shadow_slots[shadow_back];
        view.is_empty    = (shadow_count == 5'd0);
        view.is_full     = (shadow_count == cap);
        view.status      = st;
        return view;
    endfunction

    task automatic compare_field(input string what,
                                 input logic [cdq_pkg::DataW-1:0] want,
                                 input logic [cdq_pkg::DataW-1:0] got);
        if (want !== got) begin
            mismatches++;
            if (mismatches <= MaxReports) begin
                $display("mismatch %s: expected %h, got %h", what, want, got);
            end
        end
    endtask

    // result checker
    always @(posedge clk) begin
        cdq_pkg::t_out_item want;
        if (rst_n && out_valid && out_ready) begin
            if (predicted_views.size() == 0) begin
                compare_field("unexpected result", '0, 32'd1);
            end else begin
                want = predicted_views[0];
                predicted_views.delete(0);
                compare_field("front_value", want.front_value, out_item.front_value);
                compare_field("back_value", want.back_value, out_item.back_value);
                compare_field("is_empty", 32'(want.is_empty), 32'(out_item.is_empty));
                compare_field("is_full", 32'(want.is_full), 32'(out_item.is_full));
                compare_field("status", 32'(want.status), 32'(out_item.status));
            end
        end
    end

    // receiver: random stalls, plus a counted hold-off on request
    always @(posedge clk) begin
        if (rx_hold_left > 0) begin
            out_ready <= 1'b0;
            rx_hold_left--;
        end else begin
            out_ready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    task automatic send_op(input cdq_pkg::t_op kind,
                           input logic [cdq_pkg::DataW-1:0] value);
        cdq_pkg::t_in_item item;
        int                gap;
        item.op         = kind;
        item.push_value = value;
        in_item  <= item;
        in_valid <= 1'b1;
        valid_up = 1'b1;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        predicted_views.push_back(deque_apply(item));
        gap = 0;
        while ($urandom_range(99) < tx_idle_pct) gap++;
        if (gap > 0) begin
            in_valid <= 1'b0;
            valid_up = 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic drain_results();
        int waited;
        if (valid_up) begin
            in_valid <= 1'b0;
            valid_up = 1'b0;
        end
        waited = 0;
        while (predicted_views.size() != 0 && waited < DrainLimit) begin
            @(posedge clk);
            waited++;
        end
        if (predicted_views.size() != 0) begin
            compare_field("results pending", '0, 32'(predicted_views.size()));
            predicted_views.delete();
        end
        repeat (ResultLatency + 1) @(posedge clk);
    endtask

    task automatic set_capacity(input logic [cdq_pkg::CfgW-1:0] cap);
        drain_results();
        cfg_wdata <= cap;
        cfg_we    <= 1'b1;
        @(posedge clk);
        // a write empties the deque, store contents stay
        shadow_cap_reg = cap;
        shadow_front   = 4'd0;
        shadow_back    = 4'd0;
        shadow_count   = 5'd0;
        cfg_we <= 1'b0;
    endtask

    task automatic set_idle_mode(input t_idle_mode mode);
        case (mode)
            IDLE_TX: begin
                tx_idle_pct  = 74;
                rx_stall_pct = 0;
            end
            IDLE_RX: begin
                tx_idle_pct  = 0;
                rx_stall_pct = 74;
            end
            IDLE_BOTH: begin
                tx_idle_pct  = 8;
                rx_stall_pct = 8;
            end
            default: begin
                tx_idle_pct  = 0;
                rx_stall_pct = 0;
            end
        endcase
    endtask

    function automatic cdq_pkg::t_op pick_op(input int push_pct);
        if ($urandom_range(99) < push_pct) begin
            return $urandom_range(1) ? cdq_pkg::OP_PUSH_BACK : cdq_pkg::OP_PUSH_FRONT;
        end
        return $urandom_range(1) ? cdq_pkg::OP_POP_BACK : cdq_pkg::OP_POP_FRONT;
    endfunction

    task automatic test_empty_pops();
        send_op(cdq_pkg::OP_POP_FRONT, 32'h0);
        send_op(cdq_pkg::OP_POP_BACK, 32'hffff_ffff);
    endtask

    task automatic test_push_extremes();
        send_op(cdq_pkg::OP_PUSH_FRONT, 32'h7fff_ffff);
        send_op(cdq_pkg::OP_PUSH_BACK, 32'h8000_0000);
        send_op(cdq_pkg::OP_PUSH_FRONT, 32'h0);
        send_op(cdq_pkg::OP_PUSH_BACK, 32'hffff_ffff);
        send_op(cdq_pkg::OP_POP_BACK, 32'h0);
        send_op(cdq_pkg::OP_POP_FRONT, 32'h0);
        send_op(cdq_pkg::OP_POP_BACK, 32'h0);
        send_op(cdq_pkg::OP_POP_FRONT, 32'h0);
    endtask

    task automatic test_capacity_one();
        set_capacity(5'd1);
        send_op(cdq_pkg::OP_PUSH_BACK, 32'h1234_5678);
        send_op(cdq_pkg::OP_PUSH_FRONT, 32'h5555_aaaa);
        send_op(cdq_pkg::OP_POP_FRONT, 32'h0);
        send_op(cdq_pkg::OP_POP_BACK, 32'h0);
    endtask

    task automatic test_capacity_zero();
        set_capacity(5'd0);
        send_op(cdq_pkg::OP_PUSH_FRONT, 32'hdead_beef);
        send_op(cdq_pkg::OP_PUSH_BACK, 32'h0000_0001);
        send_op(cdq_pkg::OP_POP_BACK, 32'h0);
    endtask

    task automatic test_front_wrap();
        set_capacity(5'd2);
        send_op(cdq_pkg::OP_PUSH_BACK, 32'haaaa_5555);
        send_op(cdq_pkg::OP_PUSH_FRONT, 32'h0f0f_f0f0);
        send_op(cdq_pkg::OP_PUSH_BACK, 32'h1111_1111);
        send_op(cdq_pkg::OP_POP_FRONT, 32'h0);
        send_op(cdq_pkg::OP_POP_FRONT, 32'h0);
    endtask

    // capacity above DEPTH, receiver held off so the input side backs up
    task automatic test_fill_stall();
        set_capacity(5'd31);
        set_idle_mode(IDLE_NONE);
        rx_hold_left = 60;
        repeat (24) send_op(pick_op(100), $urandom());
        repeat (20) send_op(pick_op(0), $urandom());
        drain_results();
    endtask

    task automatic test_random_traffic();
        logic [4:0] caps [9];
        int         push_pct;
        int         burst_left;
        caps = '{5'd16, 5'd3, 5'd1, 5'd0, 5'd31, 5'd2,
                 5'($urandom_range(1, 16)), 5'($urandom_range(0, 31)), 5'd8};
        for (int ph = 0; ph < 9; ph++) begin
            set_capacity(caps[ph]);
            set_idle_mode(t_idle_mode'(ph % 4));
            burst_left = 0;
            push_pct   = 50;
            for (int n = 0; n < ItemsPerPhase; n++) begin
                // push-heavy and pop-heavy bursts drive the deque to full and empty
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 24);
                    case ($urandom_range(2))
                        0:       push_pct = 90;
                        1:       push_pct = 10;
                        default: push_pct = 50;
                    endcase
                end
                burst_left--;
                if (n == ItemsPerPhase / 2) drain_results();
                send_op(pick_op(push_pct), $urandom());
            end
        end
        set_idle_mode(IDLE_NONE);
    endtask

    initial begin
        foreach (shadow_slots[i]) shadow_slots[i] = '0;
        shadow_front   = 4'd0;
        shadow_back    = 4'd0;
        shadow_count   = 5'd0;
        shadow_cap_reg = 5'd16;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_pops();
        test_push_extremes();
        test_capacity_one();
        test_capacity_zero();
        test_front_wrap();
        test_fill_stall();
        test_random_traffic();
        drain_results();

        if (mismatches == 0) begin
            $display("circular_deque_tb: done, clean");
        end else begin
            $display("circular_deque_tb: done, errors");
        end
        $finish;
    end

endmodule

/* filelist.f */
hdl/cdq_pkg.sv
hdl/cdq_cell.sv
hdl/circular_deque.sv
tb/circular_deque_tb.sv
